FILE: sv/assert_macros.svh
// Assertion macros shared by the palette index bit packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at each rising edge out of reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked at each rising edge out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/pibp_pkg.sv
// Shared types, codes and helpers for the palette index bit packer.
`timescale 1ns / 1ps

package pibp_pkg;

	// APB address width: six 32-bit registers at 4-byte spacing
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Register indexes (paddr[4:2])
	localparam logic [2:0] REG_PIXEL_MODE  = 3'd0;
	localparam logic [2:0] REG_DEPTH_CODE  = 3'd1;
	localparam logic [2:0] REG_IMAGE_WIDTH = 3'd2;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
	localparam logic [2:0] REG_NOT_FOUND   = 3'd4;
	localparam logic [2:0] REG_TRANSPARENT = 3'd5;

	// Pixel modes; bit 0 clear selects msb-first order
	localparam logic [2:0] MODE_ROW_MSB = 3'd0;
	localparam logic [2:0] MODE_ROW_LSB = 3'd1;
	localparam logic [2:0] MODE_IMG_MSB = 3'd2;
	localparam logic [2:0] MODE_IMG_LSB = 3'd3;
	localparam logic [2:0] MODE_PAD_MSB = 3'd4;
	localparam logic [2:0] MODE_PAD_LSB = 3'd5;
	localparam logic [2:0] MODE_RAW     = 3'd6;

	// Depth codes
	localparam logic [1:0] DEPTH_1 = 2'd0;
	localparam logic [1:0] DEPTH_2 = 2'd1;

	// Dimension registers are 13 bits wide
	localparam int DIM_W   = 13;
	localparam int DIM_MAX = 8191;

	// Alpha low byte at or above this is opaque
	localparam logic [7:0] ALPHA_OPAQUE_MIN = 8'h80;

	typedef struct packed {
		logic [2:0]       pixel_mode;
		logic [1:0]       depth_code;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [7:0]       not_found_index;
		logic [7:0]       transparent_index;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] idx;
	} pack_req_t;

	// Bits per index for a depth code; both unnamed codes mean four
	function automatic logic [2:0] depth_bits(input logic [1:0] code);
		logic [2:0] b;
		case (code)
			DEPTH_1: b = 3'd1;
			DEPTH_2: b = 3'd2;
			default: b = 3'd4;
		endcase
		return b;
	endfunction

endpackage

FILE: sv/palette_index_bit_packer_core.sv
// Top level of the palette index bit packer: input register, palette match, packer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Palette index bit packer. Takes one item per clock while pix_stall is low.
// A palette write (cmd 1) stores a 48-bit RGB entry and gives no result. A pixel
// (cmd 0) is matched against the active palette entries in parallel, turned into
// an index and packed into bytes. Each item is registered at the input, matched
// and packed in one combinational pass, and a completed byte is loaded into the
// result register when the result side is free. So a byte passes through the
// input register and then the result register before it is presented. Sustained
// rate is one item per cycle while the byte channel does not stall. A word-padded
// row end yields a data byte and then a zero pad byte; the input register holds
// its next item until the pad byte has gone. Configure over APB while idle only.
module palette_index_bit_packer_core #(
	parameter int MAX_WIDTH    = 4096,
	parameter int MAX_HEIGHT   = 4096,
	parameter int PALETTE_SIZE = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pibp_pkg::ADDR_W-1:0]  paddr,
	input  logic [pibp_pkg::DATA_W-1:0]  pwdata,
	output logic [pibp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	// Pixel channel
	input  logic                         pix_valid,
	output logic                         pix_stall,
	input  logic                         cmd,
	input  logic [15:0]                  red,
	input  logic [15:0]                  green,
	input  logic [15:0]                  blue,
	input  logic [15:0]                  alpha,
	input  logic [3:0]                   entry_slot,
	// Byte channel
	output logic                         byte_valid,
	input  logic                         byte_stall,
	output logic [7:0]                   out_byte,
	output logic                         last
);

	pibp_pkg::cfg_t      cfg;
	pibp_pkg::pack_req_t req;
	logic                valid_s1;
	logic                cmd_s1;
	logic [47:0]         rgb_s1;
	logic [7:0]          alpha_s1;
	logic [3:0]          slot_s1;
	logic                free;
	logic                adv;
	logic                in_xfer;
	logic [7:0]          idx;

	pibp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register moves on when the result side can take it
	assign adv       = valid_s1 && free;
	assign pix_stall = valid_s1 && !free;
	assign in_xfer   = pix_valid && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1   <= cmd;
			rgb_s1   <= {red, green, blue};
			alpha_s1 <= alpha[7:0];
			slot_s1  <= entry_slot;
		end
	end

	pibp_palette #(
		.PALETTE_SIZE (PALETTE_SIZE)
	) u_palette (
		.clk      (clk),
		.wr_en    (adv && cmd_s1),
		.wr_slot  (slot_s1),
		.rgb      (rgb_s1),
		.alpha_lo (alpha_s1),
		.cfg      (cfg),
		.idx      (idx)
	);

	assign req.valid = adv && !cmd_s1;
	assign req.idx   = idx;

	pibp_packer #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req        (req),
		.free       (free),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.out_byte   (out_byte),
		.last       (last)
	);

	`ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !adv, valid_s1 && $stable(rgb_s1) && $stable(cmd_s1))

endmodule

FILE: sv/pibp_cfg.sv
// APB register file holding the packer configuration.
`timescale 1ns / 1ps

module pibp_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pibp_pkg::ADDR_W-1:0]  paddr,
	input  logic [pibp_pkg::DATA_W-1:0]  pwdata,
	output logic [pibp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output pibp_pkg::cfg_t               cfg
);

	pibp_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// Write the addressed register; addresses past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_mode        <= pibp_pkg::MODE_ROW_MSB;
			cfg_q.depth_code        <= pibp_pkg::DEPTH_1;
			cfg_q.image_width       <= pibp_pkg::DIM_W'(1);
			cfg_q.image_height      <= pibp_pkg::DIM_W'(1);
			cfg_q.not_found_index   <= 8'd0;
			cfg_q.transparent_index <= 8'd0;
		end else if (wr_en) begin
			case (reg_idx)
				pibp_pkg::REG_PIXEL_MODE:   cfg_q.pixel_mode <= pwdata[2:0];
				pibp_pkg::REG_DEPTH_CODE:   cfg_q.depth_code <= pwdata[1:0];
				pibp_pkg::REG_IMAGE_WIDTH:
					cfg_q.image_width <= pwdata[pibp_pkg::DIM_W-1:0];
				pibp_pkg::REG_IMAGE_HEIGHT:
					cfg_q.image_height <= pwdata[pibp_pkg::DIM_W-1:0];
				pibp_pkg::REG_NOT_FOUND:    cfg_q.not_found_index <= pwdata[7:0];
				pibp_pkg::REG_TRANSPARENT:  cfg_q.transparent_index <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (reg_idx)
			pibp_pkg::REG_PIXEL_MODE:   prdata = 32'(cfg_q.pixel_mode);
			pibp_pkg::REG_DEPTH_CODE:   prdata = 32'(cfg_q.depth_code);
			pibp_pkg::REG_IMAGE_WIDTH:  prdata = 32'(cfg_q.image_width);
			pibp_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_q.image_height);
			pibp_pkg::REG_NOT_FOUND:    prdata = 32'(cfg_q.not_found_index);
			pibp_pkg::REG_TRANSPARENT:  prdata = 32'(cfg_q.transparent_index);
			default:                    prdata = 32'd0;
		endcase
	end

endmodule

FILE: sv/pibp_palette.sv
// Palette storage with parallel RGB comparators and index selection.
`timescale 1ns / 1ps

module pibp_palette #(
	parameter int PALETTE_SIZE = 16
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [3:0]     wr_slot,
	input  logic [47:0]    rgb,
	input  logic [7:0]     alpha_lo,
	input  pibp_pkg::cfg_t cfg,
	output logic [7:0]     idx
);

	logic [47:0]             pal_q [PALETTE_SIZE];
	logic [PALETTE_SIZE-1:0] hit;
	logic [2:0]              bits;
	logic [4:0]              act_lim;

	// One register and one comparator per entry
	for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_entry
		always_ff @(posedge clk) begin
			if (wr_en && wr_slot == 4'(i)) begin
				pal_q[i] <= rgb;
			end
		end
		assign hit[i] = (pal_q[i] == rgb);
	end

	assign bits = pibp_pkg::depth_bits(cfg.depth_code);

	// Number of entries that take part at this depth
	always_comb begin
		case (bits)
			3'd1:    act_lim = 5'd2;
			3'd2:    act_lim = 5'd4;
			default: act_lim = 5'd16;
		endcase
	end

	// Pick the highest matching active entry, else the not-found index; a transparent pixel takes the transparent index
	always_comb begin
		idx = cfg.not_found_index;
		for (int i = 0; i < PALETTE_SIZE; i++) begin
			if (hit[i] && 5'(i) < act_lim) begin
				idx = 8'(i);
			end
		end
		if (alpha_lo < pibp_pkg::ALPHA_OPAQUE_MIN) begin
			idx = cfg.transparent_index;
		end
	end

endmodule

FILE: sv/pibp_packer.sv
// Bit packer: position counters, pack byte and the result register with pad beat.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pibp_packer #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pibp_pkg::cfg_t      cfg,
	input  pibp_pkg::pack_req_t req,
	output logic                free,
	output logic                byte_valid,
	input  logic                byte_stall,
	output logic [7:0]          out_byte,
	output logic                last
);

	localparam int WMAX = (MAX_WIDTH < pibp_pkg::DIM_MAX) ? MAX_WIDTH : pibp_pkg::DIM_MAX;
	localparam int HMAX = (MAX_HEIGHT < pibp_pkg::DIM_MAX) ? MAX_HEIGHT : pibp_pkg::DIM_MAX;
	localparam int RW   = $clog2(WMAX + 1);
	localparam int HW   = $clog2(HMAX + 1);
	localparam int TW   = $clog2(WMAX * HMAX + 1);

	// State
	logic [7:0]    pack_q;
	logic [RW-1:0] row_pos_q;
	logic [TW-1:0] img_pos_q;
	logic [TW-1:0] total_q;
	logic          valid_q;
	logic [7:0]    byte_q;
	logic          last_q;
	logic          pad_q;

	// Datapath
	logic [pibp_pkg::DIM_W-1:0] w_sat;
	logic [pibp_pkg::DIM_W-1:0] h_sat;
	logic [RW-1:0]    w_c;
	logic [HW-1:0]    h_c;
	logic [RW+HW-1:0] prod;
	logic [2:0]       bits;
	logic             raw;
	logic             img;
	logic             wpad;
	logic             msb;
	logic [RW-1:0]    row_next;
	logic             row_end;
	logic [RW:0]      row_sum;
	logic [TW-1:0]    img_next;
	logic             img_end;
	logic             at_end;
	logic [2:0]       pos_lo;
	logic [2:0]       lsb_off;
	logic [3:0]       msb_off;
	logic [2:0]       off;
	logic             full;
	logic [3:0]       idx_m;
	logic [7:0]       shifted;
	logic [7:0]       pack_new;
	logic             pad;
	logic             emit;
	logic             out_xfer;

	// Clamp dimensions to 1..max
	always_comb begin
		w_sat = cfg.image_width;
		if (cfg.image_width == '0) begin
			w_sat = pibp_pkg::DIM_W'(1);
		end else if (cfg.image_width > pibp_pkg::DIM_W'(WMAX)) begin
			w_sat = pibp_pkg::DIM_W'(WMAX);
		end
		h_sat = cfg.image_height;
		if (cfg.image_height == '0) begin
			h_sat = pibp_pkg::DIM_W'(1);
		end else if (cfg.image_height > pibp_pkg::DIM_W'(HMAX)) begin
			h_sat = pibp_pkg::DIM_W'(HMAX);
		end
	end

	assign w_c  = w_sat[RW-1:0];
	assign h_c  = h_sat[HW-1:0];
	assign prod = (RW+HW)'(w_c) * (RW+HW)'(h_c);

	// Hold the image size in a register; the user must change it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TW'(1);
		end else begin
			total_q <= prod[TW-1:0];
		end
	end

	// Mode decode
	assign bits = pibp_pkg::depth_bits(cfg.depth_code);
	assign raw  = (cfg.pixel_mode >= pibp_pkg::MODE_RAW);
	assign img  = (cfg.pixel_mode == pibp_pkg::MODE_IMG_MSB) ||
	              (cfg.pixel_mode == pibp_pkg::MODE_IMG_LSB);
	assign wpad = (cfg.pixel_mode == pibp_pkg::MODE_PAD_MSB) ||
	              (cfg.pixel_mode == pibp_pkg::MODE_PAD_LSB);
	assign msb  = !cfg.pixel_mode[0];

	// Advance positions and detect row or image end
	assign row_next = row_pos_q + RW'(1);
	assign row_end  = (row_next >= w_c);
	assign img_next = img_pos_q + TW'(1);
	assign img_end  = (img_next >= total_q);
	assign at_end   = img ? img_end : row_end;
	assign pos_lo   = img ? img_pos_q[2:0] : row_pos_q[2:0];

	// Pad when a one-bit row ends on an odd byte count
	assign row_sum = {1'b0, row_next} + (RW+1)'(7);
	assign pad     = row_end && wpad && (bits == 3'd1) && row_sum[3];

	// Slot within the byte and its bit offset
	always_comb begin
		case (bits)
			3'd1: begin
				lsb_off = pos_lo;
				full    = (pos_lo == 3'd7);
				idx_m   = {3'b000, req.idx[0]};
			end
			3'd2: begin
				lsb_off = {pos_lo[1:0], 1'b0};
				full    = (pos_lo[1:0] == 2'd3);
				idx_m   = {2'b00, req.idx[1:0]};
			end
			default: begin
				lsb_off = {pos_lo[0], 2'b00};
				full    = pos_lo[0];
				idx_m   = req.idx[3:0];
			end
		endcase
	end

	assign msb_off  = 4'd8 - {1'b0, bits} - {1'b0, lsb_off};
	assign off      = msb ? msb_off[2:0] : lsb_off;
	assign shifted  = {4'b0000, idx_m} << off;
	assign pack_new = pack_q | shifted;
	assign emit     = at_end || full;

	// Result register is free when empty or when its last beat leaves now
	assign out_xfer = valid_q && !byte_stall;
	assign free     = !valid_q || (out_xfer && !pad_q);

	// Update packing state; raw mode leaves it untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_q    <= 8'd0;
			row_pos_q <= '0;
			img_pos_q <= '0;
		end else if (req.valid && !raw) begin
			pack_q <= emit ? 8'd0 : pack_new;
			if (img) begin
				img_pos_q <= img_end ? '0 : img_next;
			end else begin
				row_pos_q <= row_end ? '0 : row_next;
			end
		end
	end

	// Result register: load a byte, or send the pending pad beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pad_q   <= 1'b0;
		end else if (req.valid && (raw || emit)) begin
			valid_q <= 1'b1;
			pad_q   <= !raw && pad;
		end else if (out_xfer) begin
			valid_q <= pad_q;
			pad_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && raw) begin
			byte_q <= req.idx;
			last_q <= 1'b1;
		end else if (req.valid && emit) begin
			byte_q <= pack_new;
			last_q <= !pad;
		end else if (out_xfer && pad_q) begin
			byte_q <= 8'd0;
			last_q <= 1'b1;
		end
	end

	assign byte_valid = valid_q;
	assign out_byte   = byte_q;
	assign last       = last_q;

	`ASSERT_IMPLIES(a_pad_not_last, clk, arst_n, valid_q && pad_q, !last_q)
	`ASSERT_NEXT(a_pad_follows, clk, arst_n, out_xfer && pad_q, valid_q && byte_q == 8'd0 && last_q)
	`ASSERT_IMPLIES(a_no_load_over_pad, clk, arst_n, req.valid, !(valid_q && pad_q))

endmodule

FILE: bench/pibp_byte_checker.sv
// Byte channel checker for the palette index bit packer: mirrors config and palette, predicts, compares.
`timescale 1ns / 1ps

module pibp_byte_checker #(
	parameter int MAX_WIDTH    = 4096,
	parameter int MAX_HEIGHT   = 4096,
	parameter int PALETTE_SIZE = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pibp_pkg::ADDR_W-1:0]  paddr,
	input  logic [pibp_pkg::DATA_W-1:0]  pwdata,
	input  logic                         pready,
	input  logic                         pix_valid,
	input  logic                         pix_stall,
	input  logic                         cmd,
	input  logic [15:0]                  red,
	input  logic [15:0]                  green,
	input  logic [15:0]                  blue,
	input  logic [15:0]                  alpha,
	input  logic [3:0]                   entry_slot,
	input  logic                         byte_valid,
	input  logic                         byte_stall,
	input  logic [7:0]                   out_byte,
	input  logic                         last,
	output int                           due_count,
	output int                           error_count
);

	typedef struct packed {
		logic [7:0] data;
		logic       tail;
	} owed_byte_t;

	// Bytes predicted but not yet transferred, oldest first
	owed_byte_t bytes_owed [$];

	// Mirrored palette and registers
	logic [47:0]                palette [16];
	logic [2:0]                 mode_cfg;
	logic [1:0]                 depth_cfg;
	logic [pibp_pkg::DIM_W-1:0] width_cfg;
	logic [pibp_pkg::DIM_W-1:0] height_cfg;
	logic [7:0]                 miss_cfg;
	logic [7:0]                 clear_cfg;

	// Packing state
	logic [7:0]  pack_acc;
	int unsigned row_pos;
	int unsigned image_pos;

	// Zero counts as one, anything past the cap saturates
	function automatic int unsigned dim_limit(input logic [pibp_pkg::DIM_W-1:0] v,
			input int unsigned cap);
		if (v == 0)
			return 1;
		if (v > cap)
			return cap;
		return 32'(v);
	endfunction

	// Map one pixel to its palette index and queue the bytes it completes
	task automatic quantize_and_pack(input logic [47:0] rgb, input logic [15:0] a);
		int unsigned bits, entries, per, pos, pos_next, total, w, slot, value, acc, i;
		logic [7:0]  index;
		logic        msb_first, wrap, pad_row;
		bits = (depth_cfg == pibp_pkg::DEPTH_1) ? 1 :
			((depth_cfg == pibp_pkg::DEPTH_2) ? 2 : 4);
		entries = 1 << bits;
		if (entries > PALETTE_SIZE)
			entries = PALETTE_SIZE;

		// Transparent first, then the highest matching entry wins
		if (a[7:0] < pibp_pkg::ALPHA_OPAQUE_MIN) begin
			index = clear_cfg;
		end else begin
			index = miss_cfg;
			for (i = 0; i < entries; i++)
				if (palette[i] == rgb)
					index = i[7:0];
		end

		// Raw mode sends the whole index and leaves the packer alone
		if (mode_cfg >= pibp_pkg::MODE_RAW) begin
			bytes_owed.push_back({index, 1'b1});
			return;
		end

		msb_first = !mode_cfg[0];
		per = 8 / bits;
		w = dim_limit(width_cfg, MAX_WIDTH);
		pad_row = 1'b0;
		if (mode_cfg == pibp_pkg::MODE_IMG_MSB || mode_cfg == pibp_pkg::MODE_IMG_LSB) begin
			total = w * dim_limit(height_cfg, MAX_HEIGHT);
			pos = image_pos;
			pos_next = pos + 1;
			wrap = pos_next >= total;
			image_pos = wrap ? 0 : pos_next;
		end else begin
			pos = row_pos;
			pos_next = pos + 1;
			wrap = pos_next >= w;
			row_pos = wrap ? 0 : pos_next;
			// Word-padded rows at one bit per index keep an even byte count
			if (wrap && mode_cfg >= pibp_pkg::MODE_PAD_MSB && bits == 1)
				pad_row = (((pos_next + 7) >> 3) & 1) != 0;
		end

		slot = pos % per;
		value = index & ((1 << bits) - 1);
		if (msb_first)
			acc = pack_acc | (value << (8 - bits * (slot + 1)));
		else
			acc = pack_acc | (value << (bits * slot));
		pack_acc = acc[7:0];

		// Flush on a full byte or at the row or image end
		if (wrap || slot + 1 == per) begin
			bytes_owed.push_back({pack_acc, !pad_row});
			pack_acc = 8'd0;
			if (pad_row)
				bytes_owed.push_back({8'd0, 1'b1});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		owed_byte_t want;
		if (!arst_n) begin
			bytes_owed.delete();
			mode_cfg    = pibp_pkg::MODE_ROW_MSB;
			depth_cfg   = pibp_pkg::DEPTH_1;
			width_cfg   = pibp_pkg::DIM_W'(1);
			height_cfg  = pibp_pkg::DIM_W'(1);
			miss_cfg    = 8'd0;
			clear_cfg   = 8'd0;
			pack_acc    = 8'd0;
			row_pos     = 0;
			image_pos   = 0;
			due_count   = 0;
			error_count = 0;
		end else begin
			// Track register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					pibp_pkg::REG_PIXEL_MODE:   mode_cfg   = pwdata[2:0];
					pibp_pkg::REG_DEPTH_CODE:   depth_cfg  = pwdata[1:0];
					pibp_pkg::REG_IMAGE_WIDTH:  width_cfg  = pwdata[pibp_pkg::DIM_W-1:0];
					pibp_pkg::REG_IMAGE_HEIGHT: height_cfg = pwdata[pibp_pkg::DIM_W-1:0];
					pibp_pkg::REG_NOT_FOUND:    miss_cfg   = pwdata[7:0];
					pibp_pkg::REG_TRANSPARENT:  clear_cfg  = pwdata[7:0];
					default: ;
				endcase
			end

			// Predict on each input transfer
			if (pix_valid && !pix_stall) begin
				if (cmd)
					palette[entry_slot] = {red, green, blue};
				else
					quantize_and_pack({red, green, blue}, alpha);
			end

			// Compare each output transfer with the oldest prediction
			if (byte_valid && !byte_stall) begin
				if (bytes_owed.size() == 0) begin
					if (error_count < 10)
						$display("%0t: unexpected byte %02h last %0b", $realtime,
							out_byte, last);
					error_count++;
				end else begin
					want = bytes_owed.pop_front();
					if (want.data !== out_byte || want.tail !== last) begin
						if (error_count < 10)
							$display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
								$realtime, want.data, want.tail, out_byte, last);
						error_count++;
					end
				end
			end
			due_count = bytes_owed.size();
		end
	end

endmodule

FILE: bench/tb.sv
// Top of the palette index bit packer bench: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int FULL_RUN     = 80;

	// Depth codes beyond the ones the package names
	localparam logic [1:0] DEPTH_4   = 2'd2;
	localparam logic [1:0] DEPTH_ALT = 2'd3;

	typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY} flow_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [pibp_pkg::ADDR_W-1:0] paddr;
	logic [pibp_pkg::DATA_W-1:0] pwdata;
	logic [pibp_pkg::DATA_W-1:0] prdata;
	logic                        pready;
	logic                        pix_valid;
	logic                        pix_stall;
	logic                        cmd;
	logic [15:0]                 red;
	logic [15:0]                 green;
	logic [15:0]                 blue;
	logic [15:0]                 alpha;
	logic [3:0]                  entry_slot;
	logic                        byte_valid;
	logic                        byte_stall;
	logic [7:0]                  out_byte;
	logic                        last;

	int          due_count;
	int          error_count;
	int          cycle_count = 0;
	int          burst_left = 0;
	logic [47:0] palette_copy [16];

	palette_index_bit_packer_core uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .cmd(cmd),
		.red(red), .green(green), .blue(blue), .alpha(alpha), .entry_slot(entry_slot),
		.byte_valid(byte_valid), .byte_stall(byte_stall), .out_byte(out_byte), .last(last)
	);

	pibp_byte_checker byte_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .cmd(cmd),
		.red(red), .green(green), .blue(blue), .alpha(alpha), .entry_slot(entry_slot),
		.byte_valid(byte_valid), .byte_stall(byte_stall), .out_byte(out_byte), .last(last),
		.due_count(due_count), .error_count(error_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// Receiver back-pressure: switch between free flow, light and heavy stalling
	initial begin
		flow_t style;
		int    span;
		int    pick;
		byte_stall = 1'b0;
		forever begin
			pick = $urandom_range(0, 2);
			style = (pick == 0) ? FLOW_FREE : ((pick == 1) ? FLOW_LIGHT : FLOW_HEAVY);
			span = $urandom_range(8, 160);
			repeat (span) begin
				@(negedge clk);
				case (style)
					FLOW_FREE:  byte_stall <= 1'b0;
					FLOW_LIGHT: byte_stall <= ($urandom_range(0, 3) == 0);
					default:    byte_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Write one register: setup phase, then access phase until pready
	task automatic write_reg(input logic [2:0] index, input logic [pibp_pkg::DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic [2:0] mode, input logic [1:0] depth,
			input logic [pibp_pkg::DIM_W-1:0] width, input logic [pibp_pkg::DIM_W-1:0] height,
			input logic [7:0] miss, input logic [7:0] clear);
		write_reg(pibp_pkg::REG_PIXEL_MODE, pibp_pkg::DATA_W'(mode));
		write_reg(pibp_pkg::REG_DEPTH_CODE, pibp_pkg::DATA_W'(depth));
		write_reg(pibp_pkg::REG_IMAGE_WIDTH, pibp_pkg::DATA_W'(width));
		write_reg(pibp_pkg::REG_IMAGE_HEIGHT, pibp_pkg::DATA_W'(height));
		write_reg(pibp_pkg::REG_NOT_FOUND, pibp_pkg::DATA_W'(miss));
		write_reg(pibp_pkg::REG_TRANSPARENT, pibp_pkg::DATA_W'(clear));
	endtask

	// Send one item inside the burst and gap pattern; hold it until the transfer
	task automatic push_item(input logic is_palette, input logic [47:0] rgb,
			input logic [15:0] a, input logic [3:0] slot);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				pix_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		pix_valid <= 1'b1;
		cmd <= is_palette;
		{red, green, blue} <= rgb;
		alpha <= a;
		entry_slot <= slot;
		if (is_palette)
			palette_copy[slot] = rgb;
		do @(posedge clk); while (pix_stall);
	endtask

	// Mostly palette colors, some one-bit misses and fresh colors
	task automatic push_pixel();
		logic [47:0] rgb;
		logic [15:0] a;
		int          pick;
		pick = $urandom_range(0, 9);
		rgb = palette_copy[$urandom_range(0, 15)];
		if (pick >= 8)
			rgb = 48'({$urandom, $urandom});
		else if (pick >= 6)
			rgb = rgb ^ (48'd1 << $urandom_range(0, 47));
		a = 16'($urandom);
		if ($urandom_range(0, 3) == 0)
			a[7:0] = 8'($urandom_range(0, 127));
		else
			a[7:0] = 8'($urandom_range(128, 255));
		push_item(1'b0, rgb, a, 4'($urandom_range(0, 15)));
	endtask

	// Rewrite a random slot: duplicates, extremes or fresh colors
	task automatic push_palette();
		logic [47:0] rgb;
		int          pick;
		pick = $urandom_range(0, 19);
		if (pick < 5)
			rgb = palette_copy[$urandom_range(0, 15)];
		else if (pick < 7)
			rgb = (pick == 5) ? 48'd0 : {48{1'b1}};
		else
			rgb = 48'({$urandom, $urandom});
		push_item(1'b1, rgb, 16'($urandom), 4'($urandom_range(0, 15)));
	endtask

	// Drop valid and hold off until every owed byte has been transferred
	task automatic drain();
		@(negedge clk);
		pix_valid <= 1'b0;
		while (due_count != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		burst_left = 0;
	endtask

	function automatic logic [7:0] pick_index();
		int pick;
		pick = $urandom_range(0, 5);
		if (pick == 0)
			return 8'd0;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	initial begin
		logic [pibp_pkg::DIM_W-1:0] width;
		logic [pibp_pkg::DIM_W-1:0] height;
		int                         phase;
		int                         random_sent;
		int                         count;
		int                         pick;
		int                         i;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_valid = 1'b0;
		cmd = 1'b0;
		red = 16'd0;
		green = 16'd0;
		blue = 16'd0;
		alpha = 16'd0;
		entry_slot = 4'd0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: four bits per index, three-pixel rows, msb-first
		configure(pibp_pkg::MODE_ROW_MSB, DEPTH_4, pibp_pkg::DIM_W'(3), pibp_pkg::DIM_W'(1),
			8'hA5, 8'h3C);
		for (i = 0; i < 16; i++) begin
			if (i == 0)
				push_item(1'b1, 48'd0, 16'd0, 4'(i));
			else if (i == 15)
				push_item(1'b1, {48{1'b1}}, 16'hFFFF, 4'(i));
			else if (i == 9)
				push_item(1'b1, palette_copy[2], 16'($urandom), 4'(i));
			else
				push_item(1'b1, 48'({$urandom, $urandom}), 16'($urandom), 4'(i));
		end
		push_item(1'b0, palette_copy[15], 16'hFFFF, 4'd0);
		push_item(1'b0, palette_copy[0], 16'h0080, 4'hF);
		push_item(1'b0, {48{1'b1}}, 16'h007F, 4'd0);
		push_item(1'b0, palette_copy[2], 16'hFF00, 4'd0);
		push_item(1'b0, palette_copy[2], 16'h00FF, 4'd0);
		push_item(1'b0, palette_copy[1] ^ 48'd1, 16'h8080, 4'd0);
		drain();

		// Directed: raw bytes with extreme indexes
		configure(pibp_pkg::MODE_RAW, pibp_pkg::DEPTH_1, pibp_pkg::DIM_W'(1),
			pibp_pkg::DIM_W'(1), 8'hFF, 8'h00);
		push_item(1'b0, palette_copy[3] ^ 48'h800000000000, 16'hFFFF, 4'd0);
		push_item(1'b0, palette_copy[0], 16'h0000, 4'd0);
		drain();

		// Random phases: step through every mode and through the depth codes in turn, rows often left open
		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 15);
			width = (pick == 0) ? '0 : ((pick == 1) ? pibp_pkg::DIM_W'(pibp_pkg::DIM_MAX) :
				pibp_pkg::DIM_W'($urandom_range(1, 24)));
			pick = $urandom_range(0, 9);
			height = (pick == 0) ? '0 : ((pick == 1) ? pibp_pkg::DIM_W'(pibp_pkg::DIM_MAX) :
				pibp_pkg::DIM_W'($urandom_range(1, 4)));
			configure(phase[2:0], phase[4:3], width, height, pick_index(), pick_index());
			count = $urandom_range(10, 60);
			repeat (count) begin
				if ($urandom_range(0, 11) == 0)
					push_palette();
				else
					push_pixel();
				random_sent++;
			end
			drain();
			phase++;
		end

		// Width past the maximum: start a saturated row, lsb-first at one bit
		configure(pibp_pkg::MODE_ROW_LSB, pibp_pkg::DEPTH_1,
			pibp_pkg::DIM_W'(pibp_pkg::DIM_MAX), pibp_pkg::DIM_W'(1),
			pick_index(), pick_index());
		repeat (FULL_RUN) push_pixel();
		drain();

		// Height past the maximum: start a saturated image of single-pixel rows
		configure(pibp_pkg::MODE_IMG_MSB, pibp_pkg::DEPTH_2, pibp_pkg::DIM_W'(1),
			pibp_pkg::DIM_W'(pibp_pkg::DIM_MAX), pick_index(), pick_index());
		repeat (FULL_RUN) push_pixel();
		drain();

		// Odd depth code in word-padded mode after the long runs
		configure(pibp_pkg::MODE_PAD_MSB, DEPTH_ALT, pibp_pkg::DIM_W'(5), pibp_pkg::DIM_W'(1),
			8'h00, 8'hFF);
		repeat (12) push_pixel();
		drain();

		repeat (16) @(negedge clk);
		if (error_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
